### rtl/core/cia_pkg.sv
// ----------------------------------------------------------------------------
// Interface adapter register file package
// Shared widths, register numbers, access codes and the access record.
// ----------------------------------------------------------------------------
`default_nettype none

package cia_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned ADDR_W = 4;

  localparam int unsigned TEN_W = 4;
  localparam int unsigned SEC_W = 7;
  localparam int unsigned MIN_W = 7;
  localparam int unsigned HR_W  = 5;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } cia_req_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_PRA     = 4'h0,
    REG_PRB     = 4'h1,
    REG_DDRA    = 4'h2,
    REG_DDRB    = 4'h3,
    REG_TA_LO   = 4'h4,
    REG_TA_HI   = 4'h5,
    REG_TB_LO   = 4'h6,
    REG_TB_HI   = 4'h7,
    REG_TOD_TEN = 4'h8,
    REG_TOD_SEC = 4'h9,
    REG_TOD_MIN = 4'hA,
    REG_TOD_HR  = 4'hB,
    REG_SDR     = 4'hC,
    REG_ICR     = 4'hD,
    REG_CRA     = 4'hE,
    REG_CRB     = 4'hF
  } cia_reg_t;

  typedef struct packed {
    cia_req_t          req;
    cia_reg_t          addr;
    logic [DATA_W-1:0] data;
  } cia_access_t;

endpackage : cia_pkg

`default_nettype wire

### rtl/core/cia_if.sv
// ----------------------------------------------------------------------------
// Interface adapter bus channels
// Request channel carrying one register access, and response channel
// carrying the byte returned for it.
// ----------------------------------------------------------------------------
`default_nettype none

interface cia_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [cia_pkg::ADDR_W-1:0] reg_addr;
  logic [cia_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output req_type, output reg_addr, output write_data,
                  input ready);
  modport sink   (input valid, input req_type, input reg_addr, input write_data,
                  output ready);
endinterface : cia_req_if

interface cia_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cia_pkg::DATA_W-1:0] read_data;

  modport source (output valid, output read_data, input ready);
  modport sink   (input valid, input read_data, output ready);
endinterface : cia_rsp_if

`default_nettype wire

### rtl/core/cia_regfile.sv
// ----------------------------------------------------------------------------
// Interface adapter register storage
// Holds the port, timer, time-of-day, interrupt and control registers,
// forms the read byte for the current access and applies its side effects.
// ----------------------------------------------------------------------------
`default_nettype none

module cia_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cia_pkg::cia_access_t       acc,
  input  wire logic                       fire,
  output logic [cia_pkg::DATA_W-1:0]      rdata
);
  import cia_pkg::*;

  logic [DATA_W-1:0]   port_a_out;
  logic [DATA_W-1:0]   port_b_out;
  logic [DATA_W-1:0]   port_a_dir;
  logic [DATA_W-1:0]   port_b_dir;
  logic [2*DATA_W-1:0] timer_a_value;
  logic [2*DATA_W-1:0] timer_b_value;
  logic [TEN_W-1:0]    clock_tenths;
  logic [SEC_W-1:0]    clock_seconds;
  logic [MIN_W-1:0]    clock_minutes;
  logic [HR_W-1:0]     clock_hours;
  logic [DATA_W-1:0]   irq_status;
  logic [DATA_W-1:0]   control_a;
  logic [DATA_W-1:0]   control_b;
  logic                clock_is_latched;
  logic [TEN_W-1:0]    snap_tenths;
  logic [SEC_W-1:0]    snap_seconds;
  logic [MIN_W-1:0]    snap_minutes;
  logic [DATA_W-1:0]   read_byte;

  // The serial shift register reads as zero, so its written value is not kept.
  always_comb begin
    unique case (acc.addr)
      REG_PRA:     read_byte = port_a_out & port_a_dir;
      REG_PRB:     read_byte = port_b_out & port_b_dir;
      REG_DDRA:    read_byte = port_a_dir;
      REG_DDRB:    read_byte = port_b_dir;
      REG_TA_LO:   read_byte = timer_a_value[DATA_W-1:0];
      REG_TA_HI:   read_byte = timer_a_value[2*DATA_W-1:DATA_W];
      REG_TB_LO:   read_byte = timer_b_value[DATA_W-1:0];
      REG_TB_HI:   read_byte = timer_b_value[2*DATA_W-1:DATA_W];
      REG_TOD_TEN: read_byte = DATA_W'(clock_is_latched ? snap_tenths : clock_tenths);
      REG_TOD_SEC: read_byte = DATA_W'(clock_is_latched ? snap_seconds : clock_seconds);
      REG_TOD_MIN: read_byte = DATA_W'(clock_is_latched ? snap_minutes : clock_minutes);
      REG_TOD_HR:  read_byte = DATA_W'(clock_hours);
      REG_SDR:     read_byte = '0;
      REG_ICR:     read_byte = irq_status;
      REG_CRA:     read_byte = control_a;
      REG_CRB:     read_byte = control_b;
    endcase
    rdata = (acc.req == REQ_WRITE) ? '0 : read_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_a_out       <= '0;
      port_b_out       <= '0;
      port_a_dir       <= '0;
      port_b_dir       <= '0;
      timer_a_value    <= '0;
      timer_b_value    <= '0;
      clock_tenths     <= '0;
      clock_seconds    <= '0;
      clock_minutes    <= '0;
      clock_hours      <= '0;
      irq_status       <= '0;
      control_a        <= '0;
      control_b        <= '0;
      clock_is_latched <= 1'b0;
      snap_tenths      <= '0;
      snap_seconds     <= '0;
      snap_minutes     <= '0;
    end else if (fire) begin
      if (acc.req == REQ_WRITE) begin
        unique case (acc.addr)
          REG_PRA:     port_a_out <= acc.data;
          REG_PRB:     port_b_out <= acc.data;
          REG_DDRA:    port_a_dir <= acc.data;
          REG_DDRB:    port_b_dir <= acc.data;
          REG_TA_LO:   timer_a_value[DATA_W-1:0] <= acc.data;
          REG_TA_HI:   timer_a_value[2*DATA_W-1:DATA_W] <= acc.data;
          REG_TB_LO:   timer_b_value[DATA_W-1:0] <= acc.data;
          REG_TB_HI:   timer_b_value[2*DATA_W-1:DATA_W] <= acc.data;
          REG_TOD_TEN: begin
            clock_tenths     <= acc.data[TEN_W-1:0];
            clock_is_latched <= 1'b0;
          end
          REG_TOD_SEC: clock_seconds <= acc.data[SEC_W-1:0];
          REG_TOD_MIN: clock_minutes <= acc.data[MIN_W-1:0];
          REG_TOD_HR:  clock_hours   <= acc.data[HR_W-1:0];
          REG_SDR:     ;
          REG_ICR:     irq_status <= acc.data;
          REG_CRA:     control_a  <= acc.data;
          REG_CRB:     control_b  <= acc.data;
        endcase
      end else begin
        if (acc.addr == REG_TOD_TEN) begin
          if (!clock_is_latched) begin
            snap_tenths      <= clock_tenths;
            snap_seconds     <= clock_seconds;
            snap_minutes     <= clock_minutes;
            clock_is_latched <= 1'b1;
          end
        end else if (acc.addr == REG_TOD_HR) begin
          clock_is_latched <= 1'b0;
        end else if (acc.addr == REG_ICR) begin
          irq_status <= '0;
        end
      end
    end
  end

  a_icr_read_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && acc.req == REQ_READ && acc.addr == REG_ICR) |=> (irq_status == '0))
    else $error("Interrupt register not cleared by a read.");

  a_tenths_read_latches: assert property (@(posedge clk) disable iff (rst)
    (fire && acc.req == REQ_READ && acc.addr == REG_TOD_TEN) |=> clock_is_latched)
    else $error("Tenths read did not latch the clock.");

  a_latch_freezes: assert property (@(posedge clk) disable iff (rst)
    (clock_is_latched && $past(clock_is_latched) && !$past(rst))
      |-> ($stable(snap_tenths) && $stable(snap_seconds) && $stable(snap_minutes)))
    else $error("Clock snapshot changed while latched.");

  a_release: assert property (@(posedge clk) disable iff (rst)
    (fire && acc.addr == REG_TOD_HR && acc.req == REQ_READ) ||
    (fire && acc.addr == REG_TOD_TEN && acc.req == REQ_WRITE) |=> !clock_is_latched)
    else $error("Clock latch not released.");

endmodule : cia_regfile

`default_nettype wire

### rtl/core/complex_interface_adapter_regs_top.sv
// ----------------------------------------------------------------------------
// Interface adapter register file, top level
// Takes register read and write transactions and returns one byte for each.
// ----------------------------------------------------------------------------
//   Channel   Role     Payload
//   req       sink     req_type, reg_addr, write_data
//   rsp       source   read_data
//
// One transaction is accepted per cycle while rsp does not stall; it passes
// through the input register and then the result register, which presents
// its byte on rsp. The register update and the read byte are formed between
// the two registers. A stall on rsp holds the result register and then the
// input register. Synchronous reset clears every register to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_interface_adapter_regs_top (
  input  wire logic clk,
  input  wire logic rst,
  cia_req_if.sink   req,
  cia_rsp_if.source rsp
);
  import cia_pkg::*;

  logic              req_valid;
  cia_access_t       req_reg;
  logic              res_valid;
  logic [DATA_W-1:0] res_data;
  logic              advance;
  logic              fire;
  logic [DATA_W-1:0] rdata;

  assign advance   = !res_valid || rsp.ready;
  assign fire      = req_valid && advance;
  assign req.ready = !req_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        req_valid <= req.valid;
      end
      if (advance) begin
        res_valid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_reg  <= '0;
      res_data <= '0;
    end else begin
      if (req.valid && req.ready) begin
        req_reg.req  <= cia_req_t'(req.req_type);
        req_reg.addr <= cia_reg_t'(req.reg_addr);
        req_reg.data <= req.write_data;
      end
      if (fire) begin
        res_data <= rdata;
      end
    end
  end

  cia_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .acc   (req_reg),
    .fire  (fire),
    .rdata (rdata)
  );

  assign rsp.valid     = res_valid;
  assign rsp.read_data = res_data;

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !rsp.ready) |=> (res_valid && $stable(res_data)))
    else $error("Result dropped while stalled.");

  a_no_fire_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !rsp.ready) |-> !fire)
    else $error("Transaction processed while result register is full.");

  a_request_held: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !fire) |=> (req_valid && $stable(req_reg)))
    else $error("Pending transaction lost.");

endmodule : complex_interface_adapter_regs_top

`default_nettype wire
